// File: rtl/indexed_priority_collection_top_macros.svh
// assertion macros for the indexed priority collection
// clk and rst must be visible where the macros are used
`ifndef INDEXED_PRIORITY_COLLECTION_TOP_MACROS_SVH
`define INDEXED_PRIORITY_COLLECTION_TOP_MACROS_SVH

// same-cycle implication
`define IPC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared constants, codes and types of the indexed priority collection.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int ENTRIES       = 64;
  localparam int ID_BITS       = $clog2(ENTRIES);
  localparam int COUNT_BITS    = ID_BITS + 1;
  localparam int PAYLOAD_BITS  = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int WORD_BITS     = PAYLOAD_BITS + PRIORITY_BITS;
  localparam int OP_BITS       = 3;
  localparam int STATUS_BITS   = 2;

  localparam logic [OP_BITS-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PROMOTE = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP     = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_LOOKUP  = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DEAD  = 2'd3;

  typedef enum logic [3:0] {
    RES_ZERO,
    RES_FULL,
    RES_ADD,
    RES_DEAD,
    RES_PROMOTE,
    RES_LOOKUP,
    RES_EMPTY,
    RES_POP,
    RES_PEEK
  } res_sel_t;

  typedef struct packed {
    logic [OP_BITS-1:0]       operation;
    logic [ID_BITS-1:0]       entry_id;
    logic [PAYLOAD_BITS-1:0]  payload_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]   status;
    logic [ID_BITS-1:0]       result_id;
    logic [PAYLOAD_BITS-1:0]  payload_out;
    logic [PRIORITY_BITS-1:0] priority_out;
    logic                     is_live;
  } rsp_t;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_step;
    logic     add_write;
    logic     promote_write;
    logic     kill_best;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               full;
    logic               id_live;
    logic               scan_last;
    logic               found;
    logic               out_free;
  } dp_status_t;

endpackage

// File: rtl/ipc_req_if.sv
// ----------------------------------------------------------------------------
// ipc_req_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface ipc_req_if;
  import ipc_pkg::*;

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input ready, input payload);
endinterface

// File: rtl/ipc_rsp_if.sv
// ----------------------------------------------------------------------------
// ipc_rsp_if
// Response channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface ipc_rsp_if;
  import ipc_pkg::*;

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input ready, input payload);
endinterface

// File: rtl/indexed_priority_collection_top.sv
// ----------------------------------------------------------------------------
// indexed_priority_collection_top
// Indexed max-priority table with sequential ids, one request at a time.
// ----------------------------------------------------------------------------
// One request is in flight at a time; each gives exactly one response. Add,
// rejected requests and unused codes respond from the decode state, promote
// and lookup after one read of the entry memory. Pop and peek read every
// entry through the single memory read port, one per cycle, and respond
// after the scan and its drain state. A new request is taken once the
// response has entered the output register; the response may wait there
// while the next request runs.
module indexed_priority_collection_top (
  input  logic       clk,
  input  logic       rst,
  ipc_req_if.sink    req,
  ipc_rsp_if.source  rsp
);
  import ipc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  ipc_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ipc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.payload),
    .rsp_data  (rsp.payload),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
  );

endmodule

// File: rtl/ipc_datapath.sv
// ----------------------------------------------------------------------------
// ipc_datapath
// Entry memory, live marks, id counter, max scan and result registers.
// ----------------------------------------------------------------------------
module ipc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ipc_pkg::ctrl_cmd_t  cmd,
  output ipc_pkg::dp_status_t sts,
  input  ipc_pkg::req_t       req_data,
  output ipc_pkg::rsp_t       rsp_data,
  output logic                rsp_valid,
  input  logic                rsp_ready
);
  import ipc_pkg::*;

  logic [OP_BITS-1:0]       op_q;
  logic [ID_BITS-1:0]       id_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;

  logic [ENTRIES-1:0]       live;
  logic [COUNT_BITS-1:0]    next_free;

  logic [WORD_BITS-1:0]     mem [ENTRIES];
  logic [WORD_BITS-1:0]     rd_word;
  logic [ID_BITS-1:0]       rd_addr;
  logic                     wr_en;
  logic [ID_BITS-1:0]       wr_addr;
  logic [WORD_BITS-1:0]     wr_data;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [PRIORITY_BITS-1:0] prio_inc;

  logic [ID_BITS-1:0]       scan_cnt;
  logic                     scan_vld;
  logic [ID_BITS-1:0]       scan_idx;
  logic                     scan_live;

  logic                     found;
  logic [ID_BITS-1:0]       best_id;
  logic [PAYLOAD_BITS-1:0]  best_pay;
  logic [PRIORITY_BITS-1:0] best_prio;

  rsp_t                     res;
  rsp_t                     res_next;
  rsp_t                     out;
  logic                     out_valid;

  assign rd_pay   = rd_word[PRIORITY_BITS +: PAYLOAD_BITS];
  assign rd_prio  = rd_word[PRIORITY_BITS-1:0];
  assign prio_inc = (&rd_prio) ? rd_prio : rd_prio + PRIORITY_BITS'(1);

  assign rd_addr = cmd.scan_step ? scan_cnt : id_q;
  assign wr_en   = cmd.add_write | cmd.promote_write;
  assign wr_addr = cmd.add_write ? next_free[ID_BITS-1:0] : id_q;
  assign wr_data = cmd.add_write ? {pay_q, {PRIORITY_BITS{1'b0}}} : {rd_pay, prio_inc};

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req_data.operation;
      id_q  <= req_data.entry_id;
      pay_q <= req_data.payload_in;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  // live marks and id counter
  always_ff @(posedge clk) begin
    if (rst) begin
      live      <= '0;
      next_free <= '0;
    end else begin
      if (cmd.add_write) begin
        live[next_free[ID_BITS-1:0]] <= 1'b1;
        next_free                    <= next_free + COUNT_BITS'(1);
      end
      if (cmd.kill_best) begin
        live[best_id] <= 1'b0;
      end
    end
  end

  // scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      scan_vld <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_cnt <= '0;
        scan_vld <= 1'b0;
        found    <= 1'b0;
      end else begin
        scan_vld <= cmd.scan_step;
        if (cmd.scan_step) begin
          scan_cnt <= scan_cnt + ID_BITS'(1);
        end
        if (scan_vld && scan_live && (!found || rd_prio >= best_prio)) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      scan_idx  <= scan_cnt;
      scan_live <= live[scan_cnt];
    end
    if (!cmd.scan_start && scan_vld && scan_live && (!found || rd_prio >= best_prio)) begin
      best_id   <= scan_idx;
      best_pay  <= rd_pay;
      best_prio <= rd_prio;
    end
  end

  // result selection
  always_comb begin
    res_next = '0;
    case (cmd.res_sel)
      RES_FULL: begin
        res_next.status = ST_FULL;
      end
      RES_ADD: begin
        res_next.status    = ST_OK;
        res_next.result_id = next_free[ID_BITS-1:0];
        res_next.is_live   = 1'b1;
      end
      RES_DEAD: begin
        res_next.status    = ST_DEAD;
        res_next.result_id = id_q;
      end
      RES_PROMOTE: begin
        res_next.status       = ST_OK;
        res_next.result_id    = id_q;
        res_next.payload_out  = rd_pay;
        res_next.priority_out = prio_inc;
        res_next.is_live      = 1'b1;
      end
      RES_LOOKUP: begin
        res_next.status       = ST_OK;
        res_next.result_id    = id_q;
        res_next.payload_out  = rd_pay;
        res_next.priority_out = rd_prio;
        res_next.is_live      = 1'b1;
      end
      RES_EMPTY: begin
        res_next.status = ST_EMPTY;
      end
      RES_POP, RES_PEEK: begin
        res_next.status       = ST_OK;
        res_next.result_id    = best_id;
        res_next.payload_out  = best_pay;
        res_next.priority_out = best_prio;
        res_next.is_live      = (cmd.res_sel == RES_PEEK);
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      out <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp_data  = out;
  assign rsp_valid = out_valid;

  assign sts.op        = op_q;
  assign sts.full      = (next_free == COUNT_BITS'(ENTRIES));
  assign sts.id_live   = live[id_q];
  assign sts.scan_last = (scan_cnt == ID_BITS'(ENTRIES - 1));
  assign sts.found     = found;
  assign sts.out_free  = !out_valid || rsp_ready;

endmodule

// File: rtl/ipc_controller.sv
// ----------------------------------------------------------------------------
// ipc_controller
// Sequencer for add, promote, lookup and the max scan of pop and peek.
// ----------------------------------------------------------------------------
module ipc_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output ipc_pkg::ctrl_cmd_t  cmd,
  input  ipc_pkg::dp_status_t sts
);
  import ipc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_ZERO;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_ADD: begin
            cmd.res_load = 1'b1;
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else begin
              cmd.res_sel   = RES_ADD;
              cmd.add_write = 1'b1;
            end
            state_next = S_RESP;
          end
          OP_PROMOTE, OP_LOOKUP: begin
            if (sts.id_live) begin
              state_next = S_FETCH;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_DEAD;
              state_next   = S_RESP;
            end
          end
          OP_POP, OP_PEEK: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            state_next   = S_RESP;
          end
        endcase
      end
      S_FETCH: begin
        cmd.res_load = 1'b1;
        if (sts.op == OP_PROMOTE) begin
          cmd.res_sel       = RES_PROMOTE;
          cmd.promote_write = 1'b1;
        end else begin
          cmd.res_sel = RES_LOOKUP;
        end
        state_next = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.res_load = 1'b1;
        if (!sts.found) begin
          cmd.res_sel = RES_EMPTY;
        end else if (sts.op == OP_POP) begin
          cmd.res_sel   = RES_POP;
          cmd.kill_best = 1'b1;
        end else begin
          cmd.res_sel = RES_PEEK;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ipc_checker.sv
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the indexed priority collection, bound to the top.
// ----------------------------------------------------------------------------
`include "indexed_priority_collection_top_macros.svh"

module ipc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ipc_pkg::rsp_t rsp_payload
);
  import ipc_pkg::*;

  `IPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_payload), "response changed while stalled")
  `IPC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready,
    !req_ready && !$rose(rsp_valid), "request overlap or early response")
  `IPC_ASSERT_IMPL(a_empty_zero, rsp_valid && rsp_payload.status == ST_EMPTY,
    rsp_payload.result_id == '0 && rsp_payload.payload_out == '0 &&
    rsp_payload.priority_out == '0 && !rsp_payload.is_live, "empty response carries data")
  `IPC_ASSERT_IMPL(a_dead_zero,
    rsp_valid && (rsp_payload.status == ST_DEAD || rsp_payload.status == ST_FULL),
    !rsp_payload.is_live && rsp_payload.payload_out == '0 &&
    rsp_payload.priority_out == '0, "rejected response carries data")

endmodule

bind indexed_priority_collection_top ipc_checker u_ipc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
